// ----- rtl/lrb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package lrb_pkg;

  // Geometry of the attached LED chains
  localparam int RINGS         = 3;
  localparam int LEDS_PER_RING = 8;

  localparam int RIDX_W   = (RINGS > 1) ? $clog2(RINGS) : 1;
  localparam int LED_W    = (LEDS_PER_RING > 1) ? $clog2(LEDS_PER_RING) : 1;
  localparam int CORR_N   = RINGS * LEDS_PER_RING;
  localparam int CORR_W   = (CORR_N > 1) ? $clog2(CORR_N) : 1;

  // Field widths
  localparam int COLOUR_W = 30;
  localparam int WORD_W   = 31;
  localparam int LEN_W    = 16;
  localparam int CNT_W    = 17;

  localparam logic [LEN_W-1:0]  FOREVER      = 16'hffff;
  localparam logic [LEN_W-1:0]  PERIOD_RST   = 16'd1000;
  localparam logic [WORD_W-1:0] CORR_WORD    = {1'b1, 10'h07f, 10'h07f, 10'h07f};

  // Item codes
  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_SET  = 1'b1;

  localparam logic [1:0] SYNC_FREE = 2'd0;
  localparam logic [1:0] SYNC_ZERO = 2'd1;
  localparam logic [1:0] SYNC_COPY = 2'd2;

  // Result of one ring step
  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic [LEN_W-1:0] left;
    logic             lit;
    logic             upd;
  } step_res_t;

endpackage

`default_nettype wire

// ----- rtl/lrb_step.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lrb_step (
  input  logic [lrb_pkg::CNT_W-1:0] cnt_i,
  input  logic [lrb_pkg::LEN_W-1:0] period_i,
  input  logic [lrb_pkg::LEN_W-1:0] on_len_i,
  input  logic [lrb_pkg::LEN_W-1:0] left_i,
  output lrb_pkg::step_res_t        res_o
);
  import lrb_pkg::*;

  logic             roll;
  logic [CNT_W-1:0] cnt0;
  logic [LEN_W-1:0] left0;

  // Roll the counter over at the period and count down finite repeats
  always_comb begin
    roll  = cnt_i >= {1'b0, period_i};
    cnt0  = roll ? '0 : cnt_i;
    left0 = left_i;
    if (roll && (left_i != '0) && (left_i != FOREVER)) begin
      left0 = left_i - 1'b1;
    end
  end

  // Decide phase and whether the frame needs a refresh
  assign res_o.cnt  = cnt0 + 1'b1;
  assign res_o.left = left0;
  assign res_o.lit  = (cnt0 < {1'b0, on_len_i}) && (left0 != '0);
  assign res_o.upd  = (cnt0 == '0) || (cnt0 == {1'b0, on_len_i});

endmodule

`default_nettype wire

// ----- rtl/led_ring_blink_frame_generator_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Blink frame generator for RINGS rings of LEDS_PER_RING chained drivers.
// A set request is written on acceptance. A tick request walks the rings
// through one shared step unit, one ring per cycle, then streams its words
// at one per cycle from the output register while the output is not stalled:
// RINGS*LEDS_PER_RING correction words on the very first tick, followed by
// RINGS*LEDS_PER_RING colour words; later ticks emit colour words only when
// any ring starts a period or reaches its on time. The input is stalled
// until the last word of a tick has been loaded into the output register.
module led_ring_blink_frame_generator_top (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        func_i,
  input  logic [1:0]  ring_i,
  input  logic [9:0]  on_red_i,
  input  logic [9:0]  on_green_i,
  input  logic [9:0]  on_blue_i,
  input  logic [9:0]  off_red_i,
  input  logic [9:0]  off_green_i,
  input  logic [9:0]  off_blue_i,
  input  logic [15:0] period_i,
  input  logic [15:0] on_time_i,
  input  logic [15:0] repeats_i,
  input  logic [1:0]  sync_mode_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [30:0] word_o,
  output logic        latch_o
);
  import lrb_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_TICK  = 4'b0010,
    S_CORR  = 4'b0100,
    S_FRAME = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [COLOUR_W-1:0] on_col_q   [RINGS];
  logic [COLOUR_W-1:0] off_col_q  [RINGS];
  logic [LEN_W-1:0]    period_q   [RINGS];
  logic [LEN_W-1:0]    on_len_q   [RINGS];
  logic [LEN_W-1:0]    left_q     [RINGS];
  logic [CNT_W-1:0]    cnt_q      [RINGS];
  logic [RINGS-1:0]    lit_q;
  logic                first_q;
  logic                upd_q;

  logic [RIDX_W-1:0]   ridx_q;
  logic [LED_W-1:0]    led_q;
  logic [CORR_W-1:0]   corr_q;

  logic                out_valid_q;
  logic [WORD_W-1:0]   word_q;
  logic                latch_q;

  logic                in_acc;
  logic                can_load;
  logic                last_ring;
  logic                last_led;
  logic                last_corr;
  logic [RIDX_W-1:0]   set_idx;
  logic                set_ok;
  step_res_t           step;

  assign in_acc    = in_valid_i && !in_stall_o;
  assign can_load  = !out_valid_q || !out_stall_i;
  assign last_ring = (ridx_q == RIDX_W'(RINGS - 1));
  assign last_led  = (led_q == LED_W'(LEDS_PER_RING - 1));
  assign last_corr = (corr_q == CORR_W'(CORR_N - 1));
  assign set_idx   = RIDX_W'(ring_i);
  assign set_ok    = (32'(ring_i) < RINGS);

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign word_o      = word_q;
  assign latch_o     = latch_q;

  // Shared per-ring step unit
  lrb_step u_step (
    .cnt_i    (cnt_q[ridx_q]),
    .period_i (period_q[ridx_q]),
    .on_len_i (on_len_q[ridx_q]),
    .left_i   (left_q[ridx_q]),
    .res_o    (step)
  );

  // Sequence tick processing and word emission
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && (func_i == FUNC_TICK)) state_d = S_TICK;
      end
      S_TICK: begin
        if (last_ring) begin
          if (first_q) begin
            state_d = S_CORR;
          end else if (upd_q || step.upd) begin
            state_d = S_FRAME;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_CORR: begin
        if (can_load && last_corr) state_d = S_FRAME;
      end
      S_FRAME: begin
        if (can_load && last_led && last_ring) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      first_q <= 1'b1;
      upd_q   <= 1'b0;
      ridx_q  <= '0;
      led_q   <= '0;
      corr_q  <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        S_IDLE: begin
          ridx_q <= '0;
          led_q  <= '0;
          corr_q <= '0;
          upd_q  <= 1'b0;
        end
        S_TICK: begin
          // Advance through the rings, collecting refresh demand
          upd_q  <= upd_q || step.upd;
          ridx_q <= last_ring ? '0 : ridx_q + 1'b1;
          if (last_ring) first_q <= 1'b0;
        end
        S_CORR: begin
          if (can_load) corr_q <= corr_q + 1'b1;
        end
        S_FRAME: begin
          if (can_load) begin
            if (last_ring) begin
              ridx_q <= '0;
              led_q  <= led_q + 1'b1;
            end else begin
              ridx_q <= ridx_q + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Hold per-ring pattern state; write on set requests and tick steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < RINGS; i++) begin
        on_col_q[i]  <= '0;
        off_col_q[i] <= '0;
        period_q[i]  <= PERIOD_RST;
        on_len_q[i]  <= '0;
        left_q[i]    <= '0;
        cnt_q[i]     <= '0;
      end
    end else begin
      if (in_acc && (func_i == FUNC_SET) && set_ok) begin
        on_col_q[set_idx]  <= {on_blue_i, on_green_i, on_red_i};
        off_col_q[set_idx] <= {off_blue_i, off_green_i, off_red_i};
        period_q[set_idx]  <= period_i;
        on_len_q[set_idx]  <= on_time_i;
        left_q[set_idx]    <= repeats_i;
        case (sync_mode_i)
          SYNC_ZERO: cnt_q[set_idx] <= '0;
          SYNC_COPY: cnt_q[set_idx] <= cnt_q[0];
          default: ;
        endcase
      end else if (state_q == S_TICK) begin
        cnt_q[ridx_q]  <= step.cnt;
        left_q[ridx_q] <= step.left;
      end
    end
  end

  // Latch each ring's phase decision for the frame
  always_ff @(posedge clk_i) begin
    if (state_q == S_TICK) lit_q[ridx_q] <= step.lit;
  end

  // Load the output register; drop valid once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (can_load) begin
      out_valid_q <= (state_q == S_CORR) || (state_q == S_FRAME);
    end
  end

  always_ff @(posedge clk_i) begin
    if (can_load) begin
      if (state_q == S_CORR) begin
        word_q  <= CORR_WORD;
        latch_q <= last_corr;
      end else if (state_q == S_FRAME) begin
        word_q  <= {1'b0, (lit_q[ridx_q] ? on_col_q[ridx_q] : off_col_q[ridx_q])};
        latch_q <= last_led && last_ring;
      end
    end
  end

endmodule

`default_nettype wire
